/* rtl/h264au_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// h264au_pkg
// Types and constants shared by the Annex B access-unit framer modules.
// ----------------------------------------------------------------------------
package h264au_pkg;

  localparam int unsigned LENGTH_BITS_DEF = 24;
  localparam int unsigned OUT_W           = 24;

  // result queue
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // prefix sizes in bytes, header byte included (without / with a leading zero byte)
  localparam int unsigned PREFIX_SHORT = 4;
  localparam int unsigned PREFIX_LONG  = 5;

  localparam logic [23:0] START_CODE = 24'h000001;
  localparam logic [7:0]  HDR_NONE   = 8'hFF;

  // NAL unit types
  localparam logic [4:0] NAL_SLICE_LO = 5'd1;
  localparam logic [4:0] NAL_IDR      = 5'd5;
  localparam logic [4:0] NAL_SEI      = 5'd6;
  localparam logic [4:0] NAL_SPS      = 5'd7;
  localparam logic [4:0] NAL_PPS      = 5'd8;
  localparam logic [4:0] NAL_AUD      = 5'd9;
  localparam logic [4:0] NAL_EOSEQ    = 5'd10;
  localparam logic [4:0] NAL_EOSTR    = 5'd11;
  localparam logic [4:0] NAL_SPS_EXT  = 5'd13;
  localparam logic [4:0] NAL_RSV_LO   = 5'd14;
  localparam logic [4:0] NAL_RSV_HI   = 5'd18;

  typedef enum logic [1:0] {
    KIND_UNIT    = 2'd0,
    KIND_DISCARD = 2'd1,
    KIND_DROP    = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       discontinuity;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [OUT_W-1:0] length;
    logic [OUT_W-1:0] header_size;
    logic             errored;
    logic             random_access;
    logic             last;
  } out_item_t;

  // results handed from the framing core to the result queue
  typedef struct packed {
    logic [1:0] count;
    out_item_t  r1;
    out_item_t  r0;
  } push_t;

endpackage
`default_nettype wire

/* rtl/h264_annexb_access_unit_framer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// h264_annexb_access_unit_framer
// Cuts an H.264 Annex B byte stream into access units, one byte per clock.
// ----------------------------------------------------------------------------
// Usage:
//  in_*  : one stream byte plus a discontinuity mark per transaction.
//  out_* : result items (unit complete, bytes discarded before sync, NAL
//          dropped after a discontinuity); a byte causes zero, one or two,
//          and the last one of a byte carries the last mark.
//  Path: a byte is held in the input register; its results then enter
//  the four-entry result queue, from which they are offered.
//  Throughput: one byte per clock. The input stalls only while the result
//  queue has fewer free entries than the current byte produces.
//  Reset (rst, synchronous): empties both stages and returns the framer to
//  the unsynced state with an empty history.
//  Receiver stall: results wait in the queue; bytes keep flowing until the
//  queue fills, then in_ready drops until results are taken.
//  LENGTH_BITS sets the width of the internal byte counters (16 to 32);
//  reported lengths saturate at 24 bits.
// ----------------------------------------------------------------------------
module h264_annexb_access_unit_framer
  import h264au_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  logic                  item_valid;
  in_item_t              item;
  logic                  take;
  push_t                 push;
  logic [FIFO_CNT_W-1:0] space;

  h264au_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .item_valid (item_valid),
    .item       (item),
    .take       (take)
  );

  h264au_core #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .space      (space),
    .take       (take),
    .push       (push)
  );

  h264au_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

/* rtl/h264au_in_reg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// h264au_in_reg
// Input register stage: holds one accepted byte until the core commits it.
// ----------------------------------------------------------------------------
module h264au_in_reg
  import h264au_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          item_valid,
  output in_item_t      item,
  input  wire logic     take
);

  assign in_ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_data;
    end
  end

endmodule
`default_nettype wire

/* rtl/h264au_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// h264au_core
// Framing state and per-byte logic: start-code search, NAL close/open,
// access-unit cut decisions and result generation.
// ----------------------------------------------------------------------------
module h264au_core
  import h264au_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  item_valid,
  input  wire in_item_t              item,
  input  wire logic [FIFO_CNT_W-1:0] space,
  output logic                       take,
  output push_t                      push
);

  localparam int unsigned LB = LENGTH_BITS;
  localparam logic [LB-1:0] ONE  = LB'(1);
  localparam logic [LB-1:0] SZ4  = LB'(PREFIX_SHORT);
  localparam logic [LB-1:0] SZ5  = LB'(PREFIX_LONG);

  function automatic logic [LB-1:0] sat_add(input logic [LB-1:0] a, input logic [LB-1:0] b);
    logic [LB:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LB] ? {LB{1'b1}} : s[LB-1:0];
  endfunction

  function automatic logic [LB-1:0] sat_sub(input logic [LB-1:0] a, input logic [LB-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

  function automatic logic [OUT_W-1:0] clamp_out(input logic [LB-1:0] v);
    logic [32:0] w;
    w = 33'(v);
    return (w > 33'(24'hFFFFFF)) ? {OUT_W{1'b1}} : w[OUT_W-1:0];
  endfunction

  function automatic logic is_slice(input logic [4:0] t);
    return (t >= NAL_SLICE_LO) && (t <= NAL_IDR);
  endfunction

  // state
  logic [39:0]   hist;
  logic [LB-1:0] unit_count;
  logic [7:0]    cur_hdr;
  logic          nal_open;
  logic [LB-1:0] nal_start;
  logic          vcl_seen;
  logic [LB-1:0] vcl_start;
  logic [7:0]    slice_hdr;
  logic          synced;
  logic          dpend;
  logic          flag_err;
  logic          flag_ra;

  logic [39:0]   hist_next;
  logic [LB-1:0] unit_count_next;
  logic [7:0]    cur_hdr_next;
  logic          nal_open_next;
  logic [LB-1:0] nal_start_next;
  logic          vcl_seen_next;
  logic [LB-1:0] vcl_start_next;
  logic [7:0]    slice_hdr_next;
  logic          synced_next;
  logic          dpend_next;
  logic          flag_err_next;
  logic          flag_ra_next;
  push_t         push_c;

  always_comb begin
    logic [LB-1:0] u;
    logic [LB-1:0] sz;
    logic [7:0]    hdr;
    logic [7:0]    psl;
    logic [4:0]    t;
    logic [4:0]    tn;
    logic          dp;
    logic          cut;
    logic          ended;
    logic          emit_unit;
    logic          emit_drop;
    logic          emit_disc;
    out_item_t     r_unit;
    out_item_t     r_drop;
    out_item_t     r_disc;

    hist_next      = {hist[31:0], item.stream_byte};
    dp             = dpend || item.discontinuity;
    u              = sat_add(unit_count, ONE);
    cur_hdr_next   = cur_hdr;
    nal_open_next  = nal_open;
    nal_start_next = nal_start;
    vcl_seen_next  = vcl_seen;
    vcl_start_next = vcl_start;
    slice_hdr_next = slice_hdr;
    synced_next    = synced;
    dpend_next     = dp;
    flag_err_next  = flag_err;
    flag_ra_next   = flag_ra;
    hdr            = hist_next[7:0];
    sz             = (hist_next[39:32] == 8'h00) ? SZ5 : SZ4;
    psl            = slice_hdr;
    t              = cur_hdr[4:0];
    tn             = hdr[4:0];
    cut            = 1'b0;
    ended          = 1'b0;
    emit_unit      = 1'b0;
    emit_drop      = 1'b0;
    emit_disc      = 1'b0;
    r_unit         = '0;
    r_drop         = '0;
    r_disc         = '0;
    r_unit.kind    = KIND_UNIT;
    r_drop.kind    = KIND_DROP;
    r_disc.kind    = KIND_DISCARD;

    if (hist_next[31:8] == START_CODE) begin
      u = sat_sub(u, sz);

      // close the NAL ended by this start code
      if (!synced) begin
        if (u != '0) begin
          emit_disc     = 1'b1;
          r_disc.length = clamp_out(u);
        end
        u           = '0;
        synced_next = 1'b1;
      end else if (nal_open) begin
        if (is_slice(t)) begin
          if (dp) flag_err_next = 1'b1;
          if (t == NAL_IDR) flag_ra_next = 1'b1;
        end else if (dp) begin
          flag_err_next = 1'b1;
          emit_drop     = 1'b1;
          r_drop.length = clamp_out(sat_sub(u, nal_start));
          if (nal_start < u) u = nal_start;
        end
      end

      u            = sat_add(u, sz);
      dpend_next   = 1'b0;
      cur_hdr_next = hdr;

      // open the new NAL, decide on a boundary
      if (is_slice(tn)) begin
        slice_hdr_next = hdr;
        if (!vcl_seen_next) begin
          vcl_seen_next  = 1'b1;
          vcl_start_next = sat_sub(u, sz);
        end else if (psl != HDR_NONE) begin
          if (((psl[4:0] == NAL_IDR) != (tn == NAL_IDR)) ||
              ((psl[6:5] == 2'b00) != (hdr[6:5] == 2'b00))) begin
            cut = 1'b1;
          end
        end
      end else if (tn == NAL_SEI) begin
        if (!vcl_seen_next) begin
          vcl_seen_next  = 1'b1;
          vcl_start_next = sat_sub(u, sz);
        end else if (slice_hdr_next != HDR_NONE) begin
          cut = 1'b1;
        end
      end else if (tn == NAL_EOSEQ || tn == NAL_EOSTR) begin
        ended = 1'b1;
      end else if (tn == NAL_SPS || tn == NAL_PPS || tn == NAL_AUD ||
                   tn == NAL_SPS_EXT || (tn >= NAL_RSV_LO && tn <= NAL_RSV_HI)) begin
        if (slice_hdr_next != HDR_NONE) cut = 1'b1;
      end

      if (cut) u = sat_sub(u, sz);

      // unit output, either at end of sequence/stream or at a cut
      if (ended || cut) begin
        if (u != '0) begin
          emit_unit            = 1'b1;
          r_unit.length        = clamp_out(u);
          r_unit.header_size   = vcl_seen_next ? clamp_out(vcl_start_next) : '0;
          r_unit.errored       = flag_err_next;
          r_unit.random_access = flag_ra_next;
        end
        u              = '0;
        vcl_seen_next  = 1'b0;
        vcl_start_next = '0;
        slice_hdr_next = HDR_NONE;
        flag_err_next  = 1'b0;
        flag_ra_next   = 1'b0;
      end

      if (cut) begin
        u = sz;
        if (is_slice(tn) || tn == NAL_SEI) begin
          vcl_seen_next  = 1'b1;
          vcl_start_next = '0;
        end
        if (is_slice(tn)) slice_hdr_next = hdr;
      end

      nal_open_next  = !ended;
      nal_start_next = ended ? '0 : sat_sub(u, sz);
    end

    unit_count_next = u;

    // order: discard or drop first, then the unit
    push_c = '0;
    if (emit_disc) begin
      push_c.r0    = r_disc;
      push_c.count = 2'd1;
    end else if (emit_drop) begin
      push_c.r0    = r_drop;
      push_c.count = 2'd1;
    end
    if (emit_unit) begin
      if (push_c.count == 2'd0) begin
        push_c.r0    = r_unit;
        push_c.count = 2'd1;
      end else begin
        push_c.r1    = r_unit;
        push_c.count = 2'd2;
      end
    end
    if (push_c.count == 2'd1) push_c.r0.last = 1'b1;
    if (push_c.count == 2'd2) push_c.r1.last = 1'b1;
  end

  assign take = item_valid && (FIFO_CNT_W'(push_c.count) <= space);

  always_comb begin
    push = push_c;
    if (!take) push.count = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist       <= '1;
      unit_count <= '0;
      cur_hdr    <= HDR_NONE;
      nal_open   <= 1'b0;
      nal_start  <= '0;
      vcl_seen   <= 1'b0;
      vcl_start  <= '0;
      slice_hdr  <= HDR_NONE;
      synced     <= 1'b0;
      dpend      <= 1'b0;
      flag_err   <= 1'b0;
      flag_ra    <= 1'b0;
    end else if (take) begin
      hist       <= hist_next;
      unit_count <= unit_count_next;
      cur_hdr    <= cur_hdr_next;
      nal_open   <= nal_open_next;
      nal_start  <= nal_start_next;
      vcl_seen   <= vcl_seen_next;
      vcl_start  <= vcl_start_next;
      slice_hdr  <= slice_hdr_next;
      synced     <= synced_next;
      dpend      <= dpend_next;
      flag_err   <= flag_err_next;
      flag_ra    <= flag_ra_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/h264au_out_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// h264au_out_fifo
// Small result queue: takes up to two results per cycle, gives one.
// ----------------------------------------------------------------------------
module h264au_out_fifo
  import h264au_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire push_t                 push,
  output logic [FIFO_CNT_W-1:0]      space,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data
);

  out_item_t             mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;
  logic                  pop;
  logic [FIFO_PTR_W-1:0] wr_ptr1;

  assign space     = FIFO_CNT_W'(FIFO_DEPTH) - count;
  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign wr_ptr1   = wr_ptr + FIFO_PTR_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_W'(push.count);
      if (pop) rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      count  <= count + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[wr_ptr] <= push.r0;
    if (push.count == 2'd2) mem[wr_ptr1] <= push.r1;
  end

endmodule
`default_nettype wire

/* dv/h264_annexb_access_unit_framer_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// h264_annexb_access_unit_framer_tb
// Feeds Annex B byte streams to the framer: a short directed part (sync and
// discard, every NAL type, cut rules, overlapping start codes,
// discontinuities), then random access units with noise. Results are
// checked against a cycle-free framing predictor. Both handshakes idle at
// random, with one long receiver hold-off and one drained pause.
// ----------------------------------------------------------------------------
module h264_annexb_access_unit_framer_tb;
  import h264au_pkg::*;

  localparam int unsigned CNT_MAX        = (1 << LENGTH_BITS_DEF) - 1;
  localparam int unsigned REPORT_MAX     = (1 << OUT_W) - 1;
  localparam logic [4:0]  NAL_FILLER     = 5'd12;
  localparam int          TOTAL_BYTES    = 1900;
  localparam int          RX_HOLD_CYCLES = 300;
  localparam int          PAUSE_SETTLE   = 4;
  localparam int          END_SETTLE     = 8;
  localparam int          CYCLE_LIMIT    = 600000;

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  h264_annexb_access_unit_framer dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------- framing predictor ----------------
  logic [39:0]  hist;
  int unsigned  unit_len;
  int unsigned  nal_begin;
  int unsigned  vcl_off;
  logic [7:0]   nal_hdr;
  logic [7:0]   slice_hdr;
  bit           nal_open;
  bit           vcl_seen;
  bit           synced;
  bit           disc_pend;
  bit           unit_err;
  bit           unit_ra;

  out_item_t    byte_reports[$];
  out_item_t    reports_due[$];

  function automatic int unsigned sat_add(int unsigned a, int unsigned b);
    longint unsigned s;
    s = longint'(a) + longint'(b);
    return (s > CNT_MAX) ? CNT_MAX : int'(s);
  endfunction

  function automatic int unsigned sat_sub(int unsigned a, int unsigned b);
    return (a > b) ? a - b : 0;
  endfunction

  function automatic bit is_slice(logic [4:0] t);
    return t >= NAL_SLICE_LO && t <= NAL_IDR;
  endfunction

  function automatic void add_report(kind_t k, int unsigned len, int unsigned hdr_off,
                                     bit err, bit ra);
    out_item_t r;
    if (byte_reports.size() >= 2) return;
    r.kind          = k;
    r.length        = OUT_W'((len > REPORT_MAX) ? REPORT_MAX : len);
    r.header_size   = OUT_W'((hdr_off > REPORT_MAX) ? REPORT_MAX : hdr_off);
    r.errored       = err;
    r.random_access = ra;
    r.last          = 1'b0;
    byte_reports.push_back(r);
  endfunction

  function automatic void close_unit();
    if (unit_len == 0) return;
    add_report(KIND_UNIT, unit_len, vcl_seen ? vcl_off : 0, unit_err, unit_ra);
    unit_len  = 0;
    vcl_seen  = 1'b0;
    vcl_off   = 0;
    slice_hdr = HDR_NONE;
    unit_err  = 1'b0;
    unit_ra   = 1'b0;
  endfunction

  function automatic void framer_reset();
    hist      = '1;
    unit_len  = 0;
    nal_hdr   = HDR_NONE;
    nal_open  = 1'b0;
    nal_begin = 0;
    vcl_seen  = 1'b0;
    vcl_off   = 0;
    slice_hdr = HDR_NONE;
    synced    = 1'b0;
    disc_pend = 1'b0;
    unit_err  = 1'b0;
    unit_ra   = 1'b0;
  endfunction

  function automatic void frame_byte(in_item_t it);
    logic [7:0]  hdr;
    logic [7:0]  prev_slice;
    logic [4:0]  t;
    logic [4:0]  ot;
    int unsigned psz;
    bit          cut;
    bit          ended;
    cut   = 1'b0;
    ended = 1'b0;
    byte_reports.delete();
    if (it.discontinuity) disc_pend = 1'b1;
    hist     = {hist[31:0], it.stream_byte};
    unit_len = sat_add(unit_len, 1);
    if (hist[31:8] != START_CODE) return;

    hdr      = hist[7:0];
    psz      = (hist[39:32] == 8'h00) ? PREFIX_LONG : PREFIX_SHORT;
    unit_len = sat_sub(unit_len, psz);

    // close the NAL ended by this start code
    if (!synced) begin
      if (unit_len > 0) add_report(KIND_DISCARD, unit_len, 0, 1'b0, 1'b0);
      unit_len = 0;
      synced   = 1'b1;
    end else if (nal_open) begin
      ot = nal_hdr[4:0];
      if (is_slice(ot)) begin
        if (disc_pend) unit_err = 1'b1;
        if (ot == NAL_IDR) unit_ra = 1'b1;
      end else if (disc_pend) begin
        unit_err = 1'b1;
        add_report(KIND_DROP, sat_sub(unit_len, nal_begin), 0, 1'b0, 1'b0);
        if (nal_begin < unit_len) unit_len = nal_begin;
      end
    end

    unit_len  = sat_add(unit_len, psz);
    disc_pend = 1'b0;
    nal_hdr   = hdr;

    t = hdr[4:0];
    if (is_slice(t)) begin
      prev_slice = slice_hdr;
      slice_hdr  = hdr;
      if (!vcl_seen) begin
        vcl_seen = 1'b1;
        vcl_off  = sat_sub(unit_len, psz);
      end else if (prev_slice != HDR_NONE) begin
        if (((prev_slice[4:0] == NAL_IDR) != (t == NAL_IDR)) ||
            ((prev_slice[6:5] == 2'b00) != (hdr[6:5] == 2'b00)))
          cut = 1'b1;
      end
    end else if (t == NAL_SEI) begin
      if (!vcl_seen) begin
        vcl_seen = 1'b1;
        vcl_off  = sat_sub(unit_len, psz);
      end else if (slice_hdr != HDR_NONE) begin
        cut = 1'b1;
      end
    end else if (t == NAL_EOSEQ || t == NAL_EOSTR) begin
      close_unit();
      ended = 1'b1;
    end else if (t == NAL_SPS || t == NAL_PPS || t == NAL_AUD || t == NAL_SPS_EXT ||
                 (t >= NAL_RSV_LO && t <= NAL_RSV_HI)) begin
      if (slice_hdr != HDR_NONE) cut = 1'b1;
    end

    // new unit starts with this NAL
    if (cut) begin
      unit_len = sat_sub(unit_len, psz);
      close_unit();
      unit_len = psz;
      if (is_slice(t) || t == NAL_SEI) begin
        vcl_seen = 1'b1;
        vcl_off  = 0;
      end
      if (is_slice(t)) slice_hdr = hdr;
    end

    nal_open  = !ended;
    nal_begin = ended ? 0 : sat_sub(unit_len, psz);

    if (byte_reports.size() > 0) byte_reports[byte_reports.size()-1].last = 1'b1;
    foreach (byte_reports[i]) reports_due.push_back(byte_reports[i]);
  endfunction

  // ---------------- result checking ----------------
  int        mismatches = 0;
  out_item_t want;

  function automatic string show(out_item_t r);
    return $sformatf("kind=%0d len=%0d hdr=%0d err=%b ra=%b last=%b",
                     r.kind, r.length, r.header_size, r.errored, r.random_access, r.last);
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (reports_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: %s", show(out_data));
      end else begin
        want = reports_due.pop_front();
        if (out_data.kind !== want.kind || out_data.length !== want.length ||
            out_data.header_size !== want.header_size || out_data.errored !== want.errored ||
            out_data.random_access !== want.random_access || out_data.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t\n  exp %s\n  got %s", $time, show(want), show(out_data));
        end
      end
    end
  end

  // ---------------- receiver ----------------
  bit rx_free     = 1'b0;
  int rx_hold_seq = 0;
  int rx_hold_ack = 0;
  int rx_wait     = 0;

  function automatic int idle_len();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  always @(negedge clk) begin
    if (rx_hold_seq != rx_hold_ack) begin
      rx_hold_ack = rx_hold_seq;
      rx_wait     = RX_HOLD_CYCLES;
    end
    if (rx_wait > 0) begin
      rx_wait--;
      out_ready <= 1'b0;
    end else if (rx_free || $urandom_range(0, 4) != 0) begin
      out_ready <= 1'b1;
    end else begin
      rx_wait = idle_len() - 1;
      out_ready <= 1'b0;
    end
  end

  // ---------------- sender ----------------
  bit tx_dense   = 1'b0;
  int disc_pct   = 0;  // per mille
  int bytes_sent = 0;

  function automatic bit rand_disc();
    return (disc_pct != 0) && ($urandom_range(0, 999) < disc_pct);
  endfunction

  function automatic logic [7:0] nal_header(logic [1:0] nri, logic [4:0] t);
    return {1'b0, nri, t};
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit d);
    in_item_t it;
    int       gap;
    it.stream_byte   = b;
    it.discontinuity = d;
    gap = (tx_dense || $urandom_range(0, 2) != 0) ? 0 : idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    frame_byte(it);
    bytes_sent++;
  endtask

  // start code, header, then payload with emulation-prevention style escapes;
  // mark sets a discontinuity on the first payload byte (the header if none)
  task automatic send_nal(input logic [7:0] hdr, input int plen, input bit long_prefix,
                          input bit mark);
    int         zrun;
    logic [7:0] b;
    zrun = 0;
    if (long_prefix) send_byte(8'h00, rand_disc());
    send_byte(8'h00, rand_disc());
    send_byte(8'h00, rand_disc());
    send_byte(8'h01, rand_disc());
    send_byte(hdr, (mark && plen == 0) || rand_disc());
    for (int i = 0; i < plen; i++) begin
      b = ($urandom_range(0, 6) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
      if (zrun >= 2) b = 8'h03;
      zrun = (b == 8'h00) ? zrun + 1 : 0;
      send_byte(b, (mark && i == 0) || rand_disc());
    end
  endtask

  task automatic wait_idle(input int settle);
    @(negedge clk);
    in_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // ---------------- tests ----------------
  task automatic test_sync_discard();
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_nal(nal_header(2'd3, NAL_SPS), 2, 1'b1, 1'b0);
  endtask

  task automatic test_all_nal_types();
    for (int t = 0; t < 32; t++)
      send_nal(nal_header(2'(t), 5'(t)), t % 3, t[0], 1'b0);
  endtask

  task automatic test_unit_cuts();
    send_nal(nal_header(2'd0, NAL_AUD), 1, 1'b0, 1'b0);
    send_nal(nal_header(2'd3, NAL_SPS), 3, 1'b1, 1'b0);
    send_nal(nal_header(2'd3, NAL_PPS), 2, 1'b0, 1'b0);
    send_nal(nal_header(2'd0, NAL_SEI), 4, 1'b0, 1'b0);
    send_nal(nal_header(2'd3, NAL_IDR), 5, 1'b1, 1'b0);
    send_nal(nal_header(2'd2, NAL_IDR), 3, 1'b0, 1'b0);
    // IDR change, then nal_ref_idc change
    send_nal(nal_header(2'd2, 5'd1), 3, 1'b0, 1'b0);
    send_nal(nal_header(2'd0, 5'd1), 2, 1'b0, 1'b0);
    send_nal(nal_header(2'd0, NAL_SEI), 2, 1'b0, 1'b0);
    send_nal(nal_header(2'd1, 5'd2), 2, 1'b0, 1'b0);
    send_nal(nal_header(2'd0, NAL_EOSTR), 0, 1'b0, 1'b0);
    send_nal(nal_header(2'd0, NAL_EOSEQ), 0, 1'b1, 1'b0);
  endtask

  task automatic test_overlapping_start();
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(nal_header(2'd0, NAL_AUD), 1'b0);
    send_byte(8'hF0, 1'b0);
    send_nal(nal_header(2'd1, 5'd3), 2, 1'b0, 1'b0);
  endtask

  task automatic test_discontinuity();
    send_nal(nal_header(2'd0, NAL_AUD), 0, 1'b0, 1'b0);
    send_nal(nal_header(2'd2, 5'd1), 3, 1'b0, 1'b1);
    send_nal(nal_header(2'd0, NAL_FILLER), 2, 1'b0, 1'b1);
    // dropped filler and the unit closed by end of stream on one byte
    send_nal(nal_header(2'd0, NAL_EOSTR), 0, 1'b0, 1'b0);
    send_nal(nal_header(2'd3, NAL_SPS), 2, 1'b1, 1'b1);
    send_nal(nal_header(2'd3, NAL_IDR), 3, 1'b0, 1'b1);
    send_nal(nal_header(2'd0, NAL_SEI), 1, 1'b0, 1'b0);
    send_nal(nal_header(2'd0, NAL_AUD), 0, 1'b0, 1'b0);
  endtask

  task automatic test_backpressure();
    rx_hold_seq++;
    tx_dense = 1'b1;
    repeat (32) begin
      send_nal(nal_header(2'd1, 5'd1), 2, 1'b0, 1'b0);
      send_nal(nal_header(2'd0, NAL_AUD), 0, 1'b0, 1'b0);
    end
    tx_dense = 1'b0;
  endtask

  task automatic test_drain_pause();
    send_nal(nal_header(2'd2, NAL_IDR), 4, 1'b0, 1'b0);
    send_nal(nal_header(2'd0, NAL_AUD), 0, 1'b0, 1'b0);
    wait_idle(PAUSE_SETTLE);
    send_nal(nal_header(2'd2, 5'd1), 4, 1'b1, 1'b0);
  endtask

  task automatic send_access_unit();
    int         r;
    bit         idr;
    logic [1:0] nri;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      // noise, broken prefixes and arbitrary headers
      repeat ($urandom_range(1, 12))
        send_byte(($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom), rand_disc());
      if (r < 4) begin
        send_byte(8'h00, rand_disc());
        send_byte(8'h00, rand_disc());
        send_byte(8'($urandom_range(2, 255)), rand_disc());
      end
      send_nal(8'($urandom), $urandom_range(0, 6), $urandom_range(0, 1) != 0, 1'b0);
    end else begin
      idr = $urandom_range(0, 3) == 0;
      nri = idr ? 2'($urandom_range(1, 3)) : 2'($urandom_range(0, 3));
      if ($urandom_range(0, 1) != 0)
        send_nal(nal_header(2'd0, NAL_AUD), $urandom_range(0, 1), $urandom_range(0, 2) == 0,
                 1'b0);
      if (idr || $urandom_range(0, 5) == 0) begin
        send_nal(nal_header(2'd3, NAL_SPS), $urandom_range(2, 8), $urandom_range(0, 1) != 0,
                 1'b0);
        send_nal(nal_header(2'd3, NAL_PPS), $urandom_range(1, 4), $urandom_range(0, 1) != 0,
                 1'b0);
      end
      if ($urandom_range(0, 2) == 0)
        send_nal(nal_header(2'd0, NAL_SEI), $urandom_range(1, 6), $urandom_range(0, 2) == 0,
                 1'b0);
      repeat ($urandom_range(1, 3))
        send_nal(nal_header(nri, idr ? NAL_IDR : 5'($urandom_range(1, 4))),
                 $urandom_range(1, 14), $urandom_range(0, 2) == 0, 1'b0);
      r = $urandom_range(0, 19);
      case (r)
        0: send_nal(nal_header(2'd0, NAL_EOSEQ), 0, 1'b0, 1'b0);
        1: send_nal(nal_header(2'd0, NAL_EOSTR), 0, 1'b0, 1'b0);
        2: send_nal(nal_header(2'd0, NAL_FILLER), $urandom_range(0, 6), 1'b0, 1'b0);
        3: send_nal(nal_header(2'($urandom), 5'($urandom_range(13, 18))),
                    $urandom_range(0, 4), 1'b0, 1'b0);
        4: send_nal(nal_header(2'($urandom), 5'($urandom_range(19, 31))),
                    $urandom_range(0, 4), 1'b1, 1'b0);
        default: ;
      endcase
    end
  endtask

  task automatic test_random_streams();
    disc_pct = 8;
    while (bytes_sent < TOTAL_BYTES) begin
      // one stretch with both sides running flat out
      tx_dense = (bytes_sent >= 1000 && bytes_sent < 1200);
      rx_free  = tx_dense;
      send_access_unit();
    end
    tx_dense = 1'b0;
    rx_free  = 1'b0;
    disc_pct = 0;
  endtask

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("h264_annexb_access_unit_framer_tb: errors");
    $finish;
  end

  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    in_data  = '0;
    framer_reset();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_sync_discard();
    test_unit_cuts();
    test_all_nal_types();
    test_overlapping_start();
    test_discontinuity();
    test_backpressure();
    test_drain_pause();
    test_random_streams();

    wait_idle(END_SETTLE);
    if (mismatches == 0) begin
      $display("h264_annexb_access_unit_framer_tb: clean");
    end else begin
      $display("h264_annexb_access_unit_framer_tb: errors");
    end
    $finish;
  end

endmodule
